// ===== design/speed_brake_steer_controller_defines.svh =====
// Assertion macros shared by the controller RTL.
`ifndef SPEED_BRAKE_STEER_CONTROLLER_DEFINES_SVH
`define SPEED_BRAKE_STEER_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is active.
`define SBSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbsc: same-cycle check failed");
// Next-cycle implication, disabled while reset is active.
`define SBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbsc: next-cycle check failed");
`else
`define SBSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/sbsc_pkg.sv =====
`default_nettype none

package sbsc_pkg;

    // Stream and configuration port widths
    localparam int S_DATA_W   = 136;
    localparam int M_DATA_W   = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_COUNT    = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_KP_GAIN        = 16'd1536;
    localparam logic [15:0] RST_WHEEL_RADIUS   = 16'd22938;
    localparam logic [15:0] RST_BRAKE_DISTANCE = 16'd1536;
    localparam logic [14:0] RST_CAMERA_GAIN    = 15'd9830;
    localparam logic [14:0] RST_MOTOR_LIMIT    = 15'd6144;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int FW_W          = 11;

    // Accumulators
    localparam int SUM_W     = 28;
    localparam int PIX_CNT_W = 20;

    // Control constants
    localparam int VLIMIT_FLOOR   = 26;
    localparam int DEFAULT_VLIMIT = 6144;
    localparam int STEER_ONE      = 16384;
    localparam int BRAKE_ONE      = 32768;
    localparam int AST_DEN        = 255 * 65536;
    localparam int AST_HALF       = AST_DEN / 2;

    // Shared divider
    localparam int DIV_N_W = 44;
    localparam int DIV_D_W = 24;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== design/sbsc_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sbsc_div
    import sbsc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] dividend,
    input  wire logic [DIV_D_W-1:0] divisor,
    output logic      [DIV_N_W-1:0] quotient,
    output div_stat_t               stat
);

    localparam int STEP_W = $clog2(DIV_N_W + 1);

    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_N_W-1:0] quot_reg, quot_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[DIV_N_W-1]};
        diff      = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            den_next  = divisor;
            step_next = STEP_W'(DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = diff[DIV_D_W-1:0];
                quot_next = {quot_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DIV_D_W-1:0];
                quot_next = {quot_reg[DIV_N_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign quotient  = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== design/speed_brake_steer_controller.sv =====
`default_nettype none

// Speed, brake and steering controller. The input stream carries camera pixel
// words (s_tuser low) and control tick words (s_tuser high). A pixel word's
// brightness goes to the left or right half sum and count, split at half of
// the frame width (capped at MAX_WIDTH); columns at or beyond that width are
// dropped. Pixels can stream back to back at one word per cycle while no tick
// is in work. A tick word returns one result word and clears the sums and
// counts. The tick runs under a small sequencer around one shared 26x17
// multiplier and one shared 44-step restoring divider. Braking and the camera
// assist both use the divider (brake ratio, two half means and the assist
// scaling); with neither, no division runs. s_tready is low while a tick is in
// work. The result sits in an output register, so new pixels are taken while
// it waits for m_tready; a later tick waits only if that register is still
// full. The user must write configuration through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
// Index 7 is ignored.

`include "speed_brake_steer_controller_defines.svh"

module speed_brake_steer_controller
    import sbsc_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // s_tdata from bit 0: pixel[7:0], column[17:8], wheel_vel_a[33:18],
    // wheel_vel_b[49:34], wheel_vel_c[65:50], wheel_vel_d[81:66],
    // target_speed[97:82], base_steer[113:98], front_dist[129:114],
    // front_valid[130], zero fill[135:131]
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // s_tuser: operation (0 pixel, 1 tick)
    input  wire logic                  s_tuser,
    // m_tdata from bit 0: motor_voltage[15:0], steer_cmd[31:16],
    // brake_cmd[47:32], measured_speed[63:48], camera_assist[79:64]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Effective width signal covers both the 11-bit frame width and MAX_WIDTH
    localparam int MW_W  = $clog2(MAX_WIDTH + 1);
    localparam int EW_W  = (MW_W > FW_W) ? MW_W : FW_W;
    localparam int SUMX_W = SUM_W + 1;

    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SPD_SH  = 18;
    localparam int DRV_SH  = 8;
    localparam int AVG_W   = 25;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MUL_SPD = 4'd1;
    localparam logic [3:0] ST_SPD     = 4'd2;
    localparam logic [3:0] ST_MUL_DRV = 4'd3;
    localparam logic [3:0] ST_DRV     = 4'd4;
    localparam logic [3:0] ST_DIV_B   = 4'd5;
    localparam logic [3:0] ST_DIV_L   = 4'd6;
    localparam logic [3:0] ST_DIV_R   = 4'd7;
    localparam logic [3:0] ST_MUL_AST = 4'd8;
    localparam logic [3:0] ST_DIV_A   = 4'd9;
    localparam logic [3:0] ST_FIN     = 4'd10;

    localparam logic signed [17:0] S16_MAX  = 18'sd32767;
    localparam logic signed [17:0] S16_MIN  = -18'sd32768;
    localparam logic signed [18:0] STEER_HI = 19'(STEER_ONE);
    localparam logic signed [18:0] STEER_LO = -19'(STEER_ONE);

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        if (v > S16_MAX)
            return 16'h7FFF;
        else if (v < S16_MIN)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    // Control state
    logic [3:0]           state_reg, state_next;
    logic                 go_reg, go_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // Configuration registers
    logic [15:0]          kp_reg, kp_next;
    logic [15:0]          radius_reg, radius_next;
    logic [15:0]          bdist_reg, bdist_next;
    logic [14:0]          cgain_reg, cgain_next;
    logic [14:0]          mlimit_reg, mlimit_next;
    logic [FW_W-1:0]      fwidth_reg, fwidth_next;
    logic [3:0]           mcount_reg, mcount_next;

    // Frame accumulators
    logic [SUM_W-1:0]     lsum_reg, lsum_next;
    logic [SUM_W-1:0]     rsum_reg, rsum_next;
    logic [PIX_CNT_W-1:0] lcnt_reg, lcnt_next;
    logic [PIX_CNT_W-1:0] rcnt_reg, rcnt_next;

    // Tick payload
    logic signed [17:0]   wsum_reg, wsum_next;
    logic signed [15:0]   target_reg, target_next;
    logic signed [15:0]   steer_in_reg, steer_in_next;
    logic [15:0]          dist_reg, dist_next;
    logic                 fvalid_reg, fvalid_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [16:0]   speed_reg, speed_next;
    logic signed [26:0]   drive_reg, drive_next;
    logic                 brk_reg, brk_next;
    logic [15:0]          brake_reg, brake_next;
    logic [AVG_W-1:0]     lavg_reg, lavg_next;
    logic [AVG_W-1:0]     ravg_reg, ravg_next;
    logic signed [17:0]   assist_reg, assist_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;

    // Input fields
    logic [7:0]           in_pixel;
    logic [9:0]           in_column;
    logic signed [15:0]   in_wa, in_wb, in_wc, in_wd;
    logic signed [15:0]   in_target, in_steer;
    logic [15:0]          in_dist;
    logic                 in_fvalid;

    assign in_pixel  = s_tdata[7:0];
    assign in_column = s_tdata[17:8];
    assign in_wa     = s_tdata[33:18];
    assign in_wb     = s_tdata[49:34];
    assign in_wc     = s_tdata[65:50];
    assign in_wd     = s_tdata[81:66];
    assign in_target = s_tdata[97:82];
    assign in_steer  = s_tdata[113:98];
    assign in_dist   = s_tdata[129:114];
    assign in_fvalid = s_tdata[130];

    // Pixel split and saturating accumulate
    logic [EW_W-1:0]      eff_w;
    logic [EW_W-1:0]      col_ext;
    logic                 in_frame;
    logic                 is_left;
    logic [SUMX_W-1:0]    lsum_add, rsum_add;
    logic [SUM_W-1:0]     lsum_sat, rsum_sat;

    assign eff_w    = (EW_W'(fwidth_reg) > EW_W'(MAX_WIDTH)) ? EW_W'(MAX_WIDTH)
                                                              : EW_W'(fwidth_reg);
    assign col_ext  = EW_W'(in_column);
    assign in_frame = col_ext < eff_w;
    assign is_left  = col_ext < (eff_w >> 1);
    assign lsum_add = {1'b0, lsum_reg} + SUMX_W'(in_pixel);
    assign rsum_add = {1'b0, rsum_reg} + SUMX_W'(in_pixel);
    assign lsum_sat = lsum_add[SUM_W] ? {SUM_W{1'b1}} : lsum_add[SUM_W-1:0];
    assign rsum_sat = rsum_add[SUM_W] ? {SUM_W{1'b1}} : rsum_add[SUM_W-1:0];

    // Shared multiplier, operands picked by the sequencer
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [17:0]        speed_err;
    logic signed [MUL_A_W-1:0] avg_diff;

    assign speed_err = target_reg - speed_reg;
    assign avg_diff  = $signed({1'b0, ravg_reg}) - $signed({1'b0, lavg_reg});

    always_comb
    begin
        unique case (state_reg)
            ST_MUL_SPD:
            begin
                mul_a = MUL_A_W'(wsum_reg);
                mul_b = $signed({1'b0, radius_reg});
            end
            ST_MUL_DRV:
            begin
                mul_a = MUL_A_W'(speed_err);
                mul_b = $signed({1'b0, kp_reg});
            end
            ST_MUL_AST:
            begin
                mul_a = avg_diff;
                mul_b = $signed({2'b00, cgain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round-to-nearest (ties away from zero) on the registered product
    logic                 prod_neg;
    logic [PROD_W-1:0]    prod_mag;
    logic [PROD_W-1:0]    spd_rnd;
    logic [PROD_W-1:0]    drv_rnd;
    logic signed [16:0]   speed_val;
    logic signed [26:0]   drive_val;

    assign prod_neg  = prod_reg[PROD_W-1];
    assign prod_mag  = prod_neg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign spd_rnd   = prod_mag + (PROD_W'(1) << (SPD_SH - 1));
    assign drv_rnd   = prod_mag + (PROD_W'(1) << (DRV_SH - 1));
    assign speed_val = prod_neg ? -$signed({1'b0, spd_rnd[SPD_SH+15:SPD_SH]})
                                :  $signed({1'b0, spd_rnd[SPD_SH+15:SPD_SH]});
    assign drive_val = prod_neg ? -$signed({1'b0, drv_rnd[DRV_SH+25:DRV_SH]})
                                :  $signed({1'b0, drv_rnd[DRV_SH+25:DRV_SH]});

    // Brake and assist conditions
    logic                 brk_cond;
    logic                 ast_en;
    logic [15:0]          bd_diff;

    assign brk_cond = fvalid_reg && (dist_reg < bdist_reg);
    assign ast_en   = (eff_w > EW_W'(1)) && (lcnt_reg != '0) && (rcnt_reg != '0);
    assign bd_diff  = bdist_reg - dist_reg;

    // Shared divider
    logic                 div_start;
    logic [DIV_N_W-1:0]   div_n;
    logic [DIV_D_W-1:0]   div_d;
    logic [DIV_N_W-1:0]   div_q;
    div_stat_t            div_stat;
    logic [15:0]          brake_q;
    logic signed [17:0]   ast_val;

    always_comb
    begin
        unique case (state_reg)
            ST_DIV_B:
            begin
                div_n = DIV_N_W'({bd_diff, 15'd0}) + DIV_N_W'(bdist_reg >> 1);
                div_d = DIV_D_W'(bdist_reg);
            end
            ST_DIV_L:
            begin
                div_n = DIV_N_W'({lsum_reg, 16'd0});
                div_d = DIV_D_W'(lcnt_reg);
            end
            ST_DIV_R:
            begin
                div_n = DIV_N_W'({rsum_reg, 16'd0});
                div_d = DIV_D_W'(rcnt_reg);
            end
            ST_DIV_A:
            begin
                div_n = DIV_N_W'(prod_mag) + DIV_N_W'(AST_HALF);
                div_d = DIV_D_W'(AST_DEN);
            end
            default:
            begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    sbsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign brake_q = (div_q > DIV_N_W'(BRAKE_ONE)) ? 16'(BRAKE_ONE) : div_q[15:0];
    assign ast_val = prod_neg ? -$signed({1'b0, div_q[16:0]})
                              :  $signed({1'b0, div_q[16:0]});

    // Final limits on the result word
    logic [14:0]          vmax;
    logic signed [26:0]   vmax_s;
    logic signed [26:0]   drive_eff;
    logic signed [26:0]   volt;
    logic signed [18:0]   steer_sum;
    logic signed [18:0]   steer_cl;
    logic                 out_free;

    assign vmax      = (mlimit_reg > 15'(VLIMIT_FLOOR)) ? mlimit_reg : 15'(DEFAULT_VLIMIT);
    assign vmax_s    = $signed({12'd0, vmax});
    assign drive_eff = brk_reg ? '0 : drive_reg;
    assign steer_sum = steer_in_reg + assist_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        priority if (mcount_reg == '0)
            volt = '0;
        else if (drive_eff > vmax_s)
            volt = vmax_s;
        else if (drive_eff < -vmax_s)
            volt = -vmax_s;
        else
            volt = drive_eff;
    end

    always_comb
    begin
        priority if (steer_sum > STEER_HI)
            steer_cl = STEER_HI;
        else if (steer_sum < STEER_LO)
            steer_cl = STEER_LO;
        else
            steer_cl = steer_sum;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        go_next       = go_reg;
        m_tvalid_next = m_tvalid_reg;
        kp_next       = kp_reg;
        radius_next   = radius_reg;
        bdist_next    = bdist_reg;
        cgain_next    = cgain_reg;
        mlimit_next   = mlimit_reg;
        fwidth_next   = fwidth_reg;
        mcount_next   = mcount_reg;
        lsum_next     = lsum_reg;
        rsum_next     = rsum_reg;
        lcnt_next     = lcnt_reg;
        rcnt_next     = rcnt_reg;
        wsum_next     = wsum_reg;
        target_next   = target_reg;
        steer_in_next = steer_in_reg;
        dist_next     = dist_reg;
        fvalid_next   = fvalid_reg;
        prod_next     = prod_reg;
        speed_next    = speed_reg;
        drive_next    = drive_reg;
        brk_next      = brk_reg;
        brake_next    = brake_reg;
        lavg_next     = lavg_reg;
        ravg_next     = ravg_reg;
        assist_next   = assist_reg;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KP_GAIN:        kp_next     = cfg_data;
                CFG_WHEEL_RADIUS:   radius_next = cfg_data;
                CFG_BRAKE_DISTANCE: bdist_next  = cfg_data;
                CFG_CAMERA_GAIN:    cgain_next  = cfg_data[14:0];
                CFG_MOTOR_LIMIT:    mlimit_next = cfg_data[14:0];
                CFG_FRAME_WIDTH:    fwidth_next = cfg_data[FW_W-1:0];
                CFG_MOTOR_COUNT:    mcount_next = cfg_data[3:0];
                default:            ;
            endcase
        end

        // drop the result word once taken; a new load below overrides
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        wsum_next     = 18'(in_wa) + 18'(in_wb) + 18'(in_wc) + 18'(in_wd);
                        target_next   = in_target;
                        steer_in_next = in_steer;
                        dist_next     = in_dist;
                        fvalid_next   = in_fvalid;
                        state_next    = ST_MUL_SPD;
                    end
                    else if (in_frame)
                    begin
                        if (is_left)
                        begin
                            lsum_next = lsum_sat;
                            if (lcnt_reg != '1)
                                lcnt_next = lcnt_reg + 1'b1;
                        end
                        else
                        begin
                            rsum_next = rsum_sat;
                            if (rcnt_reg != '1)
                                rcnt_next = rcnt_reg + 1'b1;
                        end
                    end
                end
            end
            ST_MUL_SPD:
            begin
                prod_next  = mul_p;
                state_next = ST_SPD;
            end
            ST_SPD:
            begin
                speed_next = speed_val;
                state_next = ST_MUL_DRV;
            end
            ST_MUL_DRV:
            begin
                prod_next  = mul_p;
                state_next = ST_DRV;
            end
            ST_DRV:
            begin
                drive_next = drive_val;
                brk_next   = brk_cond;
                brake_next = '0;
                priority if (brk_cond)
                begin
                    go_next    = 1'b1;
                    state_next = ST_DIV_B;
                end
                else if (ast_en)
                begin
                    go_next    = 1'b1;
                    state_next = ST_DIV_L;
                end
                else
                begin
                    assist_next = '0;
                    state_next  = ST_FIN;
                end
            end
            ST_DIV_B:
            begin
                div_start = go_reg;
                go_next   = 1'b0;
                if (div_stat.done)
                begin
                    brake_next = brake_q;
                    if (ast_en)
                    begin
                        go_next    = 1'b1;
                        state_next = ST_DIV_L;
                    end
                    else
                    begin
                        assist_next = '0;
                        state_next  = ST_FIN;
                    end
                end
            end
            ST_DIV_L:
            begin
                div_start = go_reg;
                go_next   = 1'b0;
                if (div_stat.done)
                begin
                    lavg_next  = div_q[AVG_W-1:0];
                    go_next    = 1'b1;
                    state_next = ST_DIV_R;
                end
            end
            ST_DIV_R:
            begin
                div_start = go_reg;
                go_next   = 1'b0;
                if (div_stat.done)
                begin
                    ravg_next  = div_q[AVG_W-1:0];
                    state_next = ST_MUL_AST;
                end
            end
            ST_MUL_AST:
            begin
                prod_next  = mul_p;
                go_next    = 1'b1;
                state_next = ST_DIV_A;
            end
            ST_DIV_A:
            begin
                div_start = go_reg;
                go_next   = 1'b0;
                if (div_stat.done)
                begin
                    assist_next = ast_val;
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free, then load and
                // clear the frame sums
                if (out_free)
                begin
                    m_data_next   = {sat16(assist_reg), sat16(18'(speed_reg)), brake_reg,
                                     steer_cl[15:0], volt[15:0]};
                    m_tvalid_next = 1'b1;
                    lsum_next     = '0;
                    rsum_next     = '0;
                    lcnt_next     = '0;
                    rcnt_next     = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            kp_reg       <= RST_KP_GAIN;
            radius_reg   <= RST_WHEEL_RADIUS;
            bdist_reg    <= RST_BRAKE_DISTANCE;
            cgain_reg    <= RST_CAMERA_GAIN;
            mlimit_reg   <= RST_MOTOR_LIMIT;
            fwidth_reg   <= '0;
            mcount_reg   <= '0;
            lsum_reg     <= '0;
            rsum_reg     <= '0;
            lcnt_reg     <= '0;
            rcnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            go_reg       <= go_next;
            m_tvalid_reg <= m_tvalid_next;
            kp_reg       <= kp_next;
            radius_reg   <= radius_next;
            bdist_reg    <= bdist_next;
            cgain_reg    <= cgain_next;
            mlimit_reg   <= mlimit_next;
            fwidth_reg   <= fwidth_next;
            mcount_reg   <= mcount_next;
            lsum_reg     <= lsum_next;
            rsum_reg     <= rsum_next;
            lcnt_reg     <= lcnt_next;
            rcnt_reg     <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wsum_reg     <= wsum_next;
        target_reg   <= target_next;
        steer_in_reg <= steer_in_next;
        dist_reg     <= dist_next;
        fvalid_reg   <= fvalid_next;
        prod_reg     <= prod_next;
        speed_reg    <= speed_next;
        drive_reg    <= drive_next;
        brk_reg      <= brk_next;
        brake_reg    <= brake_next;
        lavg_reg     <= lavg_next;
        ravg_reg     <= ravg_next;
        assist_reg   <= assist_next;
        m_data_reg   <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // A tick word starts the speed multiply on the next cycle
    `SBSC_ASSERT_NEXT(a_tick_starts, clk, rst_n, s_tvalid && s_tready && s_tuser, state_reg == ST_MUL_SPD)
    // No word is taken while the divider is working
    `SBSC_ASSERT_NOW(a_busy_not_ready, clk, rst_n, div_stat.busy, !s_tready)
    // Divider completion only lands in a state that waits for it
    `SBSC_ASSERT_NOW(a_done_in_div, clk, rst_n, div_stat.done, state_reg == ST_DIV_B || state_reg == ST_DIV_L || state_reg == ST_DIV_R || state_reg == ST_DIV_A)
    // Loading a result clears the frame counts
    `SBSC_ASSERT_NEXT(a_frame_cleared, clk, rst_n, (state_reg == ST_FIN) && out_free, (lcnt_reg == '0) && (rcnt_reg == '0))
    // Brake and steer stay inside their unit ranges
    `SBSC_ASSERT_NOW(a_out_ranges, clk, rst_n, m_tvalid, (m_tdata[47:32] <= 16'd32768) && ($signed(m_tdata[31:16]) <= 16'sd16384) && ($signed(m_tdata[31:16]) >= -16'sd16384))

endmodule

`default_nettype wire
